// ----- hw/rtl/per_symbol_trade_aggregator_assert.svh -----
// Assertion macros for the trade aggregator
`ifndef PER_SYMBOL_TRADE_AGGREGATOR_ASSERT_SVH
`define PER_SYMBOL_TRADE_AGGREGATOR_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define PSTA_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication
`define PSTA_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ----- hw/rtl/psta_pkg.sv -----
// ----------------------------------------------------------------------------
// psta_pkg
// Shared constants and types of the trade aggregator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package psta_pkg;
   localparam int TABLE_ENTRIES_DEF = 256;
   localparam logic [1:0] ST_UPDATED = 2'd0;
   localparam logic [1:0] ST_CREATED = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [19:0] PRICE_MAX = 20'hFFFFF;

   typedef struct packed {
      logic start;
      logic [63:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic busy;
      logic [19:0] quotient;
   } div_rsp_type;
endpackage
`default_nettype wire

// ----- hw/rtl/psta_divider.sv -----
// ----------------------------------------------------------------------------
// psta_divider
// Restoring divider, one quotient bit per cycle, clamped to 20 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module psta_divider (
   input  wire                     clock,
   input  wire                     reset,
   input  psta_pkg::div_req_type   div_req,
   output psta_pkg::div_rsp_type   div_rsp
);
   logic [63:0] quo_ff, quo_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [32:0] trial;
   logic [32:0] sub;

   always_comb begin
      quo_in = quo_ff; rem_in = rem_ff; dsr_in = dsr_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff, quo_ff[63]};
      sub = trial - {1'b0, dsr_ff};
      if (div_req.start) begin
         quo_in = div_req.dividend; rem_in = '0; dsr_in = div_req.divisor;
         cnt_in = 7'd64; busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so 32 bits hold it
         if (!sub[32]) begin
            rem_in = sub[31:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in; cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in; rem_ff <= rem_in; dsr_ff <= dsr_in;
   end

   always_comb begin
      div_rsp.done = done_ff;
      div_rsp.busy = busy_ff;
      if (dsr_ff == '0) div_rsp.quotient = '0;
      else if (quo_ff[63:20] != '0) div_rsp.quotient = psta_pkg::PRICE_MAX;
      else div_rsp.quotient = quo_ff[19:0];
   end
endmodule
`default_nettype wire

// ----- hw/rtl/per_symbol_trade_aggregator.sv -----
// ----------------------------------------------------------------------------
// per_symbol_trade_aggregator
// Per-symbol trade statistics with volume-weighted average price.
// ----------------------------------------------------------------------------
// channel | dir | fields
// req     | in  | tdata: symbol_code, trade_time, trade_quantity, trade_price
// rsp     | out | tdata: status, biggest_gap, total_volume, average_price,
//         |     |        highest_price
// One word scans the table (one memory read per cycle, a hit ends it early),
// writes the entry, divides in the shared divider, then holds an output
// state until the result is taken; a word for a full table skips the write
// and the division. req_tready is low from accept until the result is
// taken. Reset is synchronous; the fill count clears at once and entries
// past it are never compared, so the table needs no clearing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "per_symbol_trade_aggregator_assert.svh"
module per_symbol_trade_aggregator #(
   parameter int TABLE_ENTRIES = psta_pkg::TABLE_ENTRIES_DEF
) (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // symbol_code[31:0], trade_time[79:32], trade_quantity[99:80], trade_price[119:100]
   input  wire [119:0]  req_tdata,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // status[1:0], biggest_gap[49:2], total_volume[81:50], average_price[101:82],
   // highest_price[121:102]
   output logic [127:0] rsp_tdata
);
   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_CHECK = 3'd2,
      S_UPD = 3'd3, S_DIV = 3'd4, S_OUT = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [CW-1:0] used_ff;
   logic [CW-1:0] idx_ff, idx_in;
   logic [IW-1:0] hit_ff;
   logic [119:0] req_ff;
   logic [39:0] prod_ff;

   logic [31:0]  m_sym [TABLE_ENTRIES];
   logic [47:0]  m_time [TABLE_ENTRIES];
   logic [31:0]  m_vol [TABLE_ENTRIES];
   logic [63:0]  m_sum [TABLE_ENTRIES];
   logic [19:0]  m_max [TABLE_ENTRIES];
   logic [47:0]  m_gap [TABLE_ENTRIES];
   logic [31:0]  rd_sym, rd_vol; logic [47:0] rd_time, rd_gap;
   logic [63:0]  rd_sum; logic [19:0] rd_max;
   logic         rd_vld_ff;
   logic [IW-1:0] rd_idx_ff;

   logic [1:0]  o_st_ff; logic [47:0] o_gap_ff; logic [31:0] o_vol_ff;
   logic [19:0] o_avg_ff, o_max_ff; logic [63:0] o_sum_ff;

   psta_pkg::div_req_type div_req;
   psta_pkg::div_rsp_type div_rsp;

   psta_divider u_div (.clock(clock), .reset(reset), .div_req(div_req),
      .div_rsp(div_rsp));

   wire [31:0] sym = req_ff[31:0];
   wire [47:0] tt  = req_ff[79:32];
   wire [19:0] qty = req_ff[99:80];
   wire [19:0] prc = req_ff[119:100];
   wire [IW-1:0] rd_addr = idx_ff[IW-1:0];
   wire scan_hit = rd_vld_ff && rd_sym == sym;

   // update math
   wire [47:0] gap_new = tt - rd_time;
   wire [32:0] vol_sum = {1'b0, rd_vol} + {13'd0, qty};
   wire [64:0] sum_sum = {1'b0, rd_sum} + {25'd0, prod_ff};
   wire [31:0] vol_sat = vol_sum[32] ? 32'hFFFFFFFF : vol_sum[31:0];
   wire [63:0] sum_sat = sum_sum[64] ? 64'hFFFFFFFFFFFFFFFF : sum_sum[63:0];
   wire [47:0] gap_upd = (gap_new > rd_gap) ? gap_new : rd_gap;
   wire [19:0] max_upd = (prc > rd_max) ? prc : rd_max;

   logic wr_en; logic [IW-1:0] wr_idx;
   logic [31:0] w_sym, w_vol; logic [47:0] w_time, w_gap;
   logic [63:0] w_sum; logic [19:0] w_max;

   always_ff @(posedge clock) begin
      // read data freezes on a hit so the update sees the matching entry
      if (state_ff == S_SCAN && !scan_hit) begin
         rd_sym <= m_sym[rd_addr]; rd_time <= m_time[rd_addr];
         rd_vol <= m_vol[rd_addr]; rd_sum <= m_sum[rd_addr];
         rd_max <= m_max[rd_addr]; rd_gap <= m_gap[rd_addr];
         rd_idx_ff <= rd_addr;
      end
      if (wr_en) begin
         m_sym[wr_idx] <= w_sym; m_time[wr_idx] <= w_time;
         m_vol[wr_idx] <= w_vol; m_sum[wr_idx] <= w_sum;
         m_max[wr_idx] <= w_max; m_gap[wr_idx] <= w_gap;
      end
   end

   always_comb begin
      state_in = state_ff; idx_in = idx_ff;
      wr_en = 1'b0; wr_idx = hit_ff;
      w_sym = sym; w_time = tt; w_vol = vol_sat; w_sum = sum_sat;
      w_max = max_upd; w_gap = gap_upd;
      div_req.start = 1'b0; div_req.dividend = o_sum_ff; div_req.divisor = o_vol_ff;
      case (state_ff)
         S_IDLE: if (req_tvalid) begin
            state_in = S_SCAN; idx_in = '0;
         end
         S_SCAN: begin
            if (idx_ff != CW'(TABLE_ENTRIES)) idx_in = idx_ff + CW'(1);
            else state_in = S_CHECK;
            if (scan_hit && idx_ff != '0) state_in = S_UPD;
         end
         S_CHECK: begin
            if (scan_hit) state_in = S_UPD;
            else if (used_ff == CW'(TABLE_ENTRIES)) state_in = S_OUT;
            else begin
               wr_en = 1'b1; wr_idx = used_ff[IW-1:0];
               w_vol = {12'd0, qty}; w_sum = {24'd0, prod_ff};
               w_max = prc; w_gap = '0;
               state_in = S_DIV;
               div_req.start = 1'b1;
               div_req.dividend = {24'd0, prod_ff}; div_req.divisor = {12'd0, qty};
            end
         end
         S_UPD: begin
            wr_en = 1'b1; state_in = S_DIV;
            div_req.start = 1'b1; div_req.dividend = sum_sat; div_req.divisor = vol_sat;
         end
         S_DIV: if (div_rsp.done) state_in = S_OUT;
         S_OUT: if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; used_ff <= '0; rd_vld_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         state_ff <= state_in; idx_ff <= idx_in;
         // entries fill in order, so the ones below the fill count are valid
         rd_vld_ff <= (state_ff == S_SCAN) && (idx_ff < used_ff);
         if (state_ff == S_CHECK && !scan_hit && used_ff != CW'(TABLE_ENTRIES)) begin
            used_ff <= used_ff + CW'(1);
         end
      end
      if (state_ff == S_IDLE) begin
         req_ff <= req_tdata;
         prod_ff <= req_tdata[99:80] * req_tdata[119:100];
      end
      if (scan_hit && state_ff == S_SCAN) hit_ff <= rd_idx_ff;
      if (state_ff == S_CHECK) begin
         if (scan_hit) hit_ff <= rd_idx_ff;
         o_st_ff <= psta_pkg::ST_FULL; o_gap_ff <= '0; o_vol_ff <= '0;
         o_max_ff <= '0; o_avg_ff <= '0; o_sum_ff <= '0;
         if (!scan_hit && used_ff != CW'(TABLE_ENTRIES)) begin
            o_st_ff <= psta_pkg::ST_CREATED; o_vol_ff <= {12'd0, qty};
            o_max_ff <= prc;
         end
      end
      if (state_ff == S_UPD) begin
         o_st_ff <= psta_pkg::ST_UPDATED; o_gap_ff <= gap_upd; o_vol_ff <= vol_sat;
         o_max_ff <= max_upd;
      end
      if (div_rsp.done) o_avg_ff <= div_rsp.quotient;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata = {6'd0, o_max_ff, o_avg_ff, o_vol_ff, o_gap_ff, o_st_ff};

   `PSTA_ASSERT_IMP(a_one_side, clock, reset, rsp_tvalid, !req_tready)
   `PSTA_ASSERT_IMP(a_used_bound, clock, reset, 1'b1, used_ff <= CW'(TABLE_ENTRIES))
   `PSTA_ASSERT_NXT(a_div_out, clock, reset, div_rsp.done, rsp_tvalid)
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for per_symbol_trade_aggregator: random and directed
// trades, a behavioral symbol table predicts each response word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
   localparam int NUM_SLOTS = psta_pkg::TABLE_ENTRIES_DEF;
   localparam int RANDOM_TRADES = 900;

   typedef struct packed {
      logic [19:0] price;
      logic [19:0] qty;
      logic [47:0] stamp;
      logic [31:0] sym;
   } trade_type;

   typedef struct packed {
      logic [19:0] high_px;
      logic [19:0] avg_px;
      logic [31:0] volume;
      logic [47:0] gap;
      logic [1:0]  status;
   } stats_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [119:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;

   per_symbol_trade_aggregator dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // symbol table copy
   logic [31:0] tbl_sym [NUM_SLOTS];
   logic [47:0] tbl_time [NUM_SLOTS];
   logic [31:0] tbl_vol [NUM_SLOTS];
   logic [63:0] tbl_sum [NUM_SLOTS];
   logic [19:0] tbl_max [NUM_SLOTS];
   logic [47:0] tbl_gap [NUM_SLOTS];
   int slots_used = 0;

   trade_type pending_trades[$];
   stats_type expected_stats[$];
   int errors = 0;
   int words_checked = 0;
   int full_drops = 0;
   bit hold_rsp = 1'b0;
   int req_wait = 0;
   int rsp_wait = 0;

   function automatic logic [19:0] vwap(logic [63:0] s, logic [31:0] v);
      logic [63:0] q;
      if (v == '0) return '0;
      q = s / {32'd0, v};
      return (q > {44'd0, psta_pkg::PRICE_MAX}) ? psta_pkg::PRICE_MAX : q[19:0];
   endfunction

   function automatic stats_type update_symbol(trade_type t);
      stats_type r;
      logic [63:0] prod, sum;
      logic [32:0] vol;
      logic [47:0] g;
      int k;
      prod = {44'd0, t.qty} * {44'd0, t.price};
      for (k = 0; k < slots_used; k++) begin
         if (tbl_sym[k] == t.sym) begin
            g = t.stamp - tbl_time[k];
            sum = tbl_sum[k] + prod;
            if (sum < prod) sum = '1;
            vol = {1'b0, tbl_vol[k]} + {13'd0, t.qty};
            if (vol[32]) vol = 33'hFFFFFFFF;
            if (g > tbl_gap[k]) tbl_gap[k] = g;
            if (t.price > tbl_max[k]) tbl_max[k] = t.price;
            tbl_time[k] = t.stamp;
            tbl_vol[k] = vol[31:0];
            tbl_sum[k] = sum;
            r.status = psta_pkg::ST_UPDATED;
            r.gap = tbl_gap[k];
            r.volume = tbl_vol[k];
            r.avg_px = vwap(tbl_sum[k], tbl_vol[k]);
            r.high_px = tbl_max[k];
            return r;
         end
      end
      r = '0;
      if (slots_used >= NUM_SLOTS) begin
         r.status = psta_pkg::ST_FULL;
         return r;
      end
      k = slots_used;
      slots_used++;
      tbl_sym[k] = t.sym;
      tbl_time[k] = t.stamp;
      tbl_vol[k] = {12'd0, t.qty};
      tbl_sum[k] = prod;
      tbl_max[k] = t.price;
      tbl_gap[k] = '0;
      r.status = psta_pkg::ST_CREATED;
      r.volume = tbl_vol[k];
      r.avg_px = vwap(prod, tbl_vol[k]);
      r.high_px = t.price;
      return r;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %0h want %0h", what, got, want);
      errors++;
   endtask

   task automatic add_trade(trade_type t);
      pending_trades.insert(pending_trades.size(), t);
   endtask

   function automatic trade_type mk(logic [31:0] s, logic [47:0] ts, logic [19:0] q,
                                    logic [19:0] p);
      trade_type t;
      t.sym = s; t.stamp = ts; t.qty = q; t.price = p;
      return t;
   endfunction

   initial begin
      forever #10 clock = ~clock;
   end

   // driver: the front trade stays queued until accepted
   always @(posedge clock) begin
      bit stalled;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_wait <= 0;
      end else begin
         stalled = req_tvalid && !req_tready;
         if (req_tvalid && req_tready) begin
            expected_stats.insert(expected_stats.size(),
                                  update_symbol(trade_type'(req_tdata)));
            void'(pending_trades.pop_front());
         end
         if (!stalled) begin
            if (req_wait > 0) begin
               req_tvalid <= 1'b0;
               req_wait <= req_wait - 1;
            end else if (pending_trades.size() > 0) begin
               req_tdata <= pending_trades[0];
               req_tvalid <= 1'b1;
               req_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      stats_type got, want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[121:0];
            if (expected_stats.size() == 0) begin
               report_mismatch("unexpected word", '0, '0);
            end else begin
               want = expected_stats.pop_front();
               words_checked++;
               if (want.status == psta_pkg::ST_FULL) full_drops++;
               if (got.status !== want.status)
                  report_mismatch("status", 64'(got.status), 64'(want.status));
               if (got.gap !== want.gap)
                  report_mismatch("gap", 64'(got.gap), 64'(want.gap));
               if (got.volume !== want.volume)
                  report_mismatch("volume", 64'(got.volume), 64'(want.volume));
               if (got.avg_px !== want.avg_px)
                  report_mismatch("avg", 64'(got.avg_px), 64'(want.avg_px));
               if (got.high_px !== want.high_px)
                  report_mismatch("high", 64'(got.high_px), 64'(want.high_px));
            end
         end
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (rsp_wait > 0) begin
            rsp_tready <= 1'b0;
            rsp_wait <= rsp_wait - 1;
         end else begin
            rsp_tready <= 1'b1;
            if (rsp_tvalid && rsp_tready)
               rsp_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
         end
      end
   end

   initial begin
      int i, n;
      logic [31:0] s;
      logic [47:0] ts;
      for (i = 0; i < 10; i++) @(posedge clock);
      reset <= 1'b0;
      // directed: extremes, new/known, wrap gap
      add_trade(mk(32'h0, 48'h0, 20'h0, 20'h0));
      add_trade(mk(32'h0, 48'h5, 20'h0, 20'h7));
      add_trade(mk(32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 20'hFFFFF, 20'hFFFFF));
      add_trade(mk(32'hFFFFFFFF, 48'h3, 20'hFFFFF, 20'hFFFFF));
      add_trade(mk(32'hFFFFFFFF, 48'h10, 20'h1, 20'h0));
      add_trade(mk(32'h41424344, 48'h1000, 20'h3, 20'h10));
      add_trade(mk(32'h41424344, 48'h0800, 20'h7, 20'h3));
      add_trade(mk(32'h41424344, 48'h0900, 20'h2, 20'h11));
      // large trades piling up on one symbol
      for (i = 0; i < 4200; i += 300)
         add_trade(mk(32'h53415400, 48'(256 + i), 20'hFFFFF, 20'hFFFFF));
      wait (pending_trades.size() == 0 && expected_stats.size() == 0);
      // long receiver hold-off: input must stall
      hold_rsp = 1'b1;
      for (i = 0; i < 5; i++)
         add_trade(mk(32'h484F4C44, 48'(16 * i), 20'(5 + i), 20'h9));
      repeat (2000) @(posedge clock);
      hold_rsp = 1'b0;
      wait (pending_trades.size() == 0 && expected_stats.size() == 0);
      // random: mostly recurring symbols with rising times
      ts = 48'h0;
      for (n = 0; n < RANDOM_TRADES; n++) begin
         case ($urandom_range(0, 9))
            0, 1: s = $urandom;
            default: s = 32'(32'h52000000 + $urandom_range(0, 40));
         endcase
         ts = ($urandom_range(0, 19) == 0) ? 48'({$urandom, $urandom})
                                           : 48'(ts + $urandom_range(0, 5000));
         add_trade(mk(s, ts, 20'($urandom),
                      $urandom_range(0, 1) ? 20'($urandom) : 20'($urandom_range(0, 300))));
         if (n == 450) begin
            wait (pending_trades.size() == 0 && expected_stats.size() == 0);
         end
      end
      // fill past table capacity
      for (i = 0; i < NUM_SLOTS + 20; i++)
         add_trade(mk(32'(32'h70000000 + i), 48'h1, 20'h1, 20'h2));
      wait (pending_trades.size() == 0 && expected_stats.size() == 0);
      repeat (400) @(posedge clock);
      $display("checked %0d result words, %0d dropped on full table, %0d symbols stored",
               words_checked, full_drops, slots_used);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #(64'd20 * 64'd3000000);
      $display("== FAIL ==");
      $finish;
   end
endmodule
